// File: rtl/pat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pat_pkg
// Shared constants, types and controller codes of the pending ack tracker.
// ----------------------------------------------------------------------------
package pat_pkg;

  localparam int unsigned ENTRIES = 8;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned SLOT_W  = 3;

  localparam logic [DATA_W-1:0] TIMEOUT_RESET = 32'd30000;
  localparam logic [DATA_W-1:0] TIME_MAX      = '1;

  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_CHECK  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic last;
  } status_t;

endpackage

// File: rtl/pat_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pat_ctrl
// Sequencer: accepts an item, walks the table one entry a cycle, commits.
// ----------------------------------------------------------------------------
module pat_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  pat_pkg::status_t status_i,
  output pat_pkg::cmd_t    cmd_o,
  output logic             busy_o,
  output logic             done_o
);
  import pat_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    done_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.hit || status_i.last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd_o.commit = 1'b1;
        done_o       = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/pat_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pat_datapath
// Entry table, item registers, timeout register and the per-entry scan logic.
// ----------------------------------------------------------------------------
module pat_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pat_pkg::cmd_t                 cmd_i,
  output pat_pkg::status_t              status_o,
  input  logic                          kind_i,
  input  logic [pat_pkg::DATA_W-1:0]    sender_node_i,
  input  logic [pat_pkg::DATA_W-1:0]    packet_ident_i,
  input  logic [pat_pkg::DATA_W-1:0]    now_ms_i,
  input  logic                          cfg_we_i,
  input  logic [pat_pkg::DATA_W-1:0]    cfg_data_i,
  output logic                          matched_o,
  output logic [pat_pkg::SLOT_W-1:0]    slot_o
);
  import pat_pkg::*;

  logic [DATA_W-1:0] timeout_q;

  logic              kind_q;
  logic [DATA_W-1:0] node_q;
  logic [DATA_W-1:0] ident_q;
  logic [DATA_W-1:0] now_q;

  logic [DATA_W-1:0] entry_node_q  [ENTRIES];
  logic [DATA_W-1:0] entry_ident_q [ENTRIES];
  logic [DATA_W-1:0] entry_time_q  [ENTRIES];
  logic [ENTRIES-1:0] live_q;

  logic [IDX_W-1:0]  idx_q;
  logic [IDX_W-1:0]  pick_q;
  logic [DATA_W-1:0] oldest_q;
  logic              found_q;

  logic [DATA_W-1:0] cur_time;
  logic [DATA_W-1:0] age;
  logic              expired;
  logic              cur_live;
  logic              key_eq;

  assign cur_time = entry_time_q[idx_q];
  assign cur_live = live_q[idx_q];
  assign age      = now_q - cur_time;
  assign expired  = (age >= timeout_q);
  assign key_eq   = (entry_node_q[idx_q] == node_q) && (entry_ident_q[idx_q] == ident_q);

  always_comb begin
    if (kind_q == KIND_RECORD) begin
      status_o.hit = !cur_live || expired;
    end else begin
      status_o.hit = cur_live && key_eq && !expired;
    end
    status_o.last = (idx_q == IDX_W'(ENTRIES - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_data_i;
    end
  end

  // item capture and scan bookkeeping
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q   <= kind_i;
      node_q   <= sender_node_i;
      ident_q  <= packet_ident_i;
      now_q    <= now_ms_i;
      idx_q    <= '0;
      pick_q   <= '0;
      oldest_q <= TIME_MAX;
      found_q  <= 1'b0;
    end else if (cmd_i.scan) begin
      idx_q <= idx_q + IDX_W'(1);
      if (status_o.hit) begin
        pick_q  <= idx_q;
        found_q <= 1'b1;
      end else if (kind_q == KIND_RECORD && cur_time < oldest_q) begin
        pick_q   <= idx_q;
        oldest_q <= cur_time;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && kind_q == KIND_RECORD) begin
      entry_node_q[pick_q]  <= node_q;
      entry_ident_q[pick_q] <= ident_q;
      entry_time_q[pick_q]  <= now_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= '0;
    end else if (cmd_i.commit) begin
      if (kind_q == KIND_RECORD) begin
        live_q[pick_q] <= 1'b1;
      end else if (found_q) begin
        live_q[pick_q] <= 1'b0;
      end
    end
  end

  assign matched_o = cmd_i.commit && (kind_q == KIND_CHECK) && found_q;
  assign slot_o    = SLOT_W'(pick_q);

endmodule

// File: rtl/pending_ack_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pending_ack_tracker
// Table of packets waiting for an acknowledgement, with record and check.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken at a clock edge with start_i high and busy_o low.
//   kind_i 0 records sender_node_i / packet_ident_i stamped with now_ms_i,
//   kind_i 1 looks up and clears a live, unexpired matching entry.
//   Exactly one result beat follows each item: done_o is high for one cycle
//   with matched_o and slot_o valid; the receiver cannot stall it.
//   The table is walked one entry a cycle by the scan counter, stopping at
//   the first entry that ends the search, and busy_o drops the cycle after
//   done_o.
//   The timeout register is written through cfg_valid_i / cfg_data_i; the
//   user must do so only while the block is idle, which the block itself
//   does not enforce. cfg_ready_o is always high.
//   Reset clears every live bit, loads the timeout with 30000 ms and leaves
//   the block idle; no clearing pass is needed.
// ----------------------------------------------------------------------------
module pending_ack_tracker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic                       kind_i,
  input  logic [pat_pkg::DATA_W-1:0] sender_node_i,
  input  logic [pat_pkg::DATA_W-1:0] packet_ident_i,
  input  logic [pat_pkg::DATA_W-1:0] now_ms_i,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [pat_pkg::DATA_W-1:0] cfg_data_i,
  output logic                       done_o,
  output logic                       matched_o,
  output logic [pat_pkg::SLOT_W-1:0] slot_o
);
  import pat_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  pat_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  pat_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .kind_i         (kind_i),
    .sender_node_i  (sender_node_i),
    .packet_ident_i (packet_ident_i),
    .now_ms_i       (now_ms_i),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .matched_o      (matched_o),
    .slot_o         (slot_o)
  );

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o && !done_o)
    else $error("accepted item did not start a scan");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o && !done_o)
    else $error("result beat not followed by idle");

  a_matched_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    matched_o |-> done_o)
    else $error("match flagged outside a result beat");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o && $past(busy_o))
    else $error("result beat without a scan before it");
`endif

endmodule

// File: tb/pending_ack_tracker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pending_ack_tracker_tb
// Self-checking bench for the pending acknowledgement table. A short table of
// directed record and check beats opens the run, then several timeout settings
// (the extremes among them) are each followed by random traffic. Most of it
// records packets and looks them up again while time moves around the expiry
// boundary and across the 32-bit wrap. A predictor kept in step with every
// accepted beat gives the expected matched flag and slot, save for typed rows.
// ----------------------------------------------------------------------------
module pending_ack_tracker_tb;
  import pat_pkg::*;

  localparam int unsigned LIMIT       = 400000;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_ITEMS = 172;
  localparam int unsigned NODE_POOL   = 6;
  localparam int unsigned RECENT_MAX  = 12;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic              matched;
    logic [SLOT_W-1:0] slot;
  } ack_result_t;

  typedef struct packed {
    logic        typed;
    ack_result_t res;
  } hand_value_t;

  typedef struct packed {
    logic              kind;
    logic [DATA_W-1:0] node;
    logic [DATA_W-1:0] ident;
    logic [DATA_W-1:0] now;
    hand_value_t       hand;
  } dir_row_t;

  typedef struct packed {
    logic [DATA_W-1:0] node;
    logic [DATA_W-1:0] ident;
  } packet_key_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic              kind_i;
  logic [DATA_W-1:0] sender_node_i;
  logic [DATA_W-1:0] packet_ident_i;
  logic [DATA_W-1:0] now_ms_i;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [DATA_W-1:0] cfg_data_i;
  logic              done_o;
  logic              matched_o;
  logic [SLOT_W-1:0] slot_o;

  // predictor copy of the table and the timeout register
  logic [DATA_W-1:0] tbl_node  [ENTRIES];
  logic [DATA_W-1:0] tbl_ident [ENTRIES];
  logic [DATA_W-1:0] tbl_time  [ENTRIES];
  logic              tbl_live  [ENTRIES];
  logic [DATA_W-1:0] cur_tmo;

  ack_result_t       ack_result_q[$];
  hand_value_t       hand_value_q[$];
  dir_row_t          dir_tbl[$];
  packet_key_t       recent_q[$];
  logic [DATA_W-1:0] node_pool [NODE_POOL];
  logic [DATA_W-1:0] tmo_plan  [PHASES];
  logic [DATA_W-1:0] cur_now;

  int unsigned cycle_cnt;
  int unsigned err_cnt;
  int unsigned n_items;
  int unsigned n_records;
  int unsigned n_checks;
  int unsigned n_hits;
  int unsigned n_results;

  ack_result_t mon_got;
  ack_result_t mon_want;
  hand_value_t mon_hand;

  pending_ack_tracker u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .kind_i         (kind_i),
    .sender_node_i  (sender_node_i),
    .packet_ident_i (packet_ident_i),
    .now_ms_i       (now_ms_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .done_o         (done_o),
    .matched_o      (matched_o),
    .slot_o         (slot_o)
  );

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic aged_out(int unsigned idx, logic [DATA_W-1:0] now);
    logic [DATA_W-1:0] age;
    age = now - tbl_time[idx];
    return age >= cur_tmo;
  endfunction

  function automatic ack_result_t track_step(logic kind, logic [DATA_W-1:0] node,
                                             logic [DATA_W-1:0] ident,
                                             logic [DATA_W-1:0] now);
    ack_result_t       r;
    int unsigned       pick;
    logic              found;
    logic [DATA_W-1:0] oldest;
    r      = '0;
    pick   = 0;
    found  = 1'b0;
    oldest = TIME_MAX;
    if (kind == KIND_RECORD) begin
      for (int unsigned i = 0; i < ENTRIES; i++) begin
        if (!found) begin
          if (!tbl_live[i] || aged_out(i, now)) begin
            pick  = i;
            found = 1'b1;
          end else if (tbl_time[i] < oldest) begin
            oldest = tbl_time[i];
            pick   = i;
          end
        end
      end
      tbl_node[pick]  = node;
      tbl_ident[pick] = ident;
      tbl_time[pick]  = now;
      tbl_live[pick]  = 1'b1;
    end else begin
      for (int unsigned i = 0; i < ENTRIES; i++) begin
        if (!found && tbl_live[i] && tbl_node[i] == node && tbl_ident[i] == ident &&
            !aged_out(i, now)) begin
          tbl_live[i] = 1'b0;
          found       = 1'b1;
          r.matched   = 1'b1;
          pick        = i;
        end
      end
    end
    r.slot = SLOT_W'(pick);
    return r;
  endfunction

  function automatic dir_row_t mk_row(logic kind, logic [DATA_W-1:0] node,
                                      logic [DATA_W-1:0] ident, logic [DATA_W-1:0] now,
                                      logic typed, logic matched, logic [SLOT_W-1:0] slot);
    dir_row_t row;
    row.kind             = kind;
    row.node             = node;
    row.ident            = ident;
    row.now              = now;
    row.hand.typed       = typed;
    row.hand.res.matched = matched;
    row.hand.res.slot    = slot;
    return row;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 12);
    return $urandom_range(13, 60);
  endfunction

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result checking and prediction on accepted beats
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        cur_tmo = cfg_data_i;
      end
      if (done_o) begin
        n_results++;
        mon_got.matched = matched_o;
        mon_got.slot    = slot_o;
        if (ack_result_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS) begin
            $display("unexpected result beat: matched=%0b slot=%0d", matched_o, slot_o);
          end
        end else begin
          mon_want = ack_result_q.pop_front();
          if (mon_got.matched !== mon_want.matched || mon_got.slot !== mon_want.slot) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS) begin
              $display("mismatch at result %0d: matched exp %0b got %0b, slot exp %0d got %0d",
                       n_results, mon_want.matched, mon_got.matched,
                       mon_want.slot, mon_got.slot);
            end
          end
        end
      end
      if (start_i && !busy_o) begin
        mon_hand = (hand_value_q.size() != 0) ? hand_value_q.pop_front() : '0;
        mon_want = track_step(kind_i, sender_node_i, packet_ident_i, now_ms_i);
        if (mon_hand.typed) begin
          mon_want = mon_hand.res;
        end
        ack_result_q.push_back(mon_want);
        n_items++;
        if (kind_i == KIND_RECORD) begin
          n_records++;
        end else begin
          n_checks++;
        end
        if (mon_want.matched) begin
          n_hits++;
        end
      end
    end
  end

  task automatic drive_item(input logic kind, input logic [DATA_W-1:0] node,
                            input logic [DATA_W-1:0] ident, input logic [DATA_W-1:0] now,
                            input hand_value_t hand, input int unsigned gap);
    @(negedge clk_i);
    if (gap > 0) begin
      start_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    hand_value_q.push_back(hand);
    start_i        = 1'b1;
    kind_i         = kind;
    sender_node_i  = node;
    packet_ident_i = ident;
    now_ms_i       = now;
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
  endtask

  task automatic write_timeout(input logic [DATA_W-1:0] value);
    @(negedge clk_i);
    start_i     = 1'b0;
    cfg_valid_i = 1'b1;
    cfg_data_i  = value;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    start_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (ack_result_q.size() == 0 && hand_value_q.size() == 0) break;
    end
    repeat (12) @(posedge clk_i);
  endtask

  task automatic random_item(input logic idle_ok);
    logic              kind;
    packet_key_t       key;
    hand_value_t       hand;
    logic [DATA_W-1:0] step_scale;
    int unsigned       r;
    int unsigned       s;
    int unsigned       bit_sel;
    hand       = '0;
    step_scale = (cur_tmo >> 3) + 1;
    kind       = logic'($urandom_range(0, 1));
    r          = $urandom_range(0, 99);
    s          = $urandom_range(0, 99);
    // move time: stand still, creep, land on the expiry edge, jump, or near the wrap
    if (s < 35) begin
      cur_now = cur_now;
    end else if (s < 75) begin
      cur_now = cur_now + $urandom_range(0, step_scale);
    end else if (s < 85) begin
      cur_now = cur_now + cur_tmo - $urandom_range(0, 1);
    end else if (s < 95) begin
      cur_now = cur_now + $urandom;
    end else begin
      cur_now = TIME_MAX - $urandom_range(0, 64);
    end
    if (kind == KIND_RECORD) begin
      if (r < 80) begin
        key.node  = node_pool[$urandom_range(0, NODE_POOL - 1)];
        key.ident = (r < 40) ? DATA_W'($urandom_range(0, 7)) : DATA_W'($urandom);
        recent_q.push_back(key);
        if (recent_q.size() > RECENT_MAX) begin
          void'(recent_q.pop_front());
        end
      end else begin
        key.node  = $urandom;
        key.ident = $urandom;
      end
    end else begin
      if (recent_q.size() != 0 && r < 80) begin
        key = recent_q[$urandom_range(0, recent_q.size() - 1)];
        if (r >= 65) begin
          // near miss on one bit of node or ident
          bit_sel = $urandom_range(0, DATA_W - 1);
          if ($urandom_range(0, 1) != 0) begin
            key.node[bit_sel] = ~key.node[bit_sel];
          end else begin
            key.ident[bit_sel] = ~key.ident[bit_sel];
          end
        end
      end else begin
        key.node  = $urandom;
        key.ident = $urandom;
      end
    end
    drive_item(kind, key.node, key.ident, cur_now, hand, idle_ok ? gap_len() : 0);
  endtask

  initial begin
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    kind_i         = KIND_RECORD;
    sender_node_i  = '0;
    packet_ident_i = '0;
    now_ms_i       = '0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    cycle_cnt      = 0;
    err_cnt        = 0;
    n_items        = 0;
    n_records      = 0;
    n_checks       = 0;
    n_hits         = 0;
    n_results      = 0;
    cur_tmo        = TIMEOUT_RESET;
    cur_now        = '0;
    for (int unsigned i = 0; i < ENTRIES; i++) begin
      tbl_node[i]  = '0;
      tbl_ident[i] = '0;
      tbl_time[i]  = '0;
      tbl_live[i]  = 1'b0;
    end
    node_pool[0] = '0;
    node_pool[1] = TIME_MAX;
    node_pool[2] = 32'h0000_0001;
    node_pool[3] = 32'h8000_0000;
    node_pool[4] = $urandom;
    node_pool[5] = $urandom;
    tmo_plan[0] = 32'd1;
    tmo_plan[1] = 32'd0;
    tmo_plan[2] = TIME_MAX;
    tmo_plan[3] = $urandom_range(20, 400);
    tmo_plan[4] = TIMEOUT_RESET;
    tmo_plan[5] = $urandom;

    // empty table, fill, full-table eviction, expiry edge, wraparound
    dir_tbl.push_back(mk_row(KIND_CHECK,  32'h0, 32'h0, 32'd0, 1'b1, 1'b0, 3'd0));
    dir_tbl.push_back(mk_row(KIND_RECORD, 32'h0, 32'h0, 32'd0, 1'b1, 1'b0, 3'd0));
    dir_tbl.push_back(mk_row(KIND_RECORD, TIME_MAX, TIME_MAX, 32'd100, 1'b1, 1'b0, 3'd1));
    dir_tbl.push_back(mk_row(KIND_CHECK,  TIME_MAX, TIME_MAX, 32'd200, 1'b1, 1'b1, 3'd1));
    dir_tbl.push_back(mk_row(KIND_CHECK,  TIME_MAX, TIME_MAX, 32'd200, 1'b1, 1'b0, 3'd0));
    dir_tbl.push_back(mk_row(KIND_RECORD, 32'd5, 32'd7, 32'd1000, 1'b1, 1'b0, 3'd1));
    dir_tbl.push_back(mk_row(KIND_CHECK,  32'd5, 32'd8, 32'd1100, 1'b1, 1'b0, 3'd0));
    dir_tbl.push_back(mk_row(KIND_CHECK,  32'd6, 32'd7, 32'd1100, 1'b1, 1'b0, 3'd0));
    for (int unsigned k = 0; k < 6; k++) begin
      dir_tbl.push_back(mk_row(KIND_RECORD, 32'h10 + k, 32'h10 + k, 32'd2000 + 1000 * k,
                               1'b0, 1'b0, 3'd0));
    end
    dir_tbl.push_back(mk_row(KIND_RECORD, 32'hA5A5_A5A5, 32'hDEAD_BEEF, 32'd8000,
                             1'b0, 1'b0, 3'd0));
    dir_tbl.push_back(mk_row(KIND_CHECK,  32'd5, 32'd7, 32'd31000, 1'b0, 1'b0, 3'd0));
    dir_tbl.push_back(mk_row(KIND_CHECK,  32'h12, 32'h12, 32'd31000, 1'b0, 1'b0, 3'd0));
    dir_tbl.push_back(mk_row(KIND_RECORD, 32'd1, 32'd1, 32'd31000, 1'b0, 1'b0, 3'd0));
    dir_tbl.push_back(mk_row(KIND_RECORD, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FF00,
                             1'b0, 1'b0, 3'd0));
    dir_tbl.push_back(mk_row(KIND_CHECK,  32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0100,
                             1'b0, 1'b0, 3'd0));
    dir_tbl.push_back(mk_row(KIND_CHECK,  32'h5555_5555, 32'hAAAA_AAAA, TIME_MAX,
                             1'b0, 1'b0, 3'd0));

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_tbl[i]) begin
      drive_item(dir_tbl[i].kind, dir_tbl[i].node, dir_tbl[i].ident, dir_tbl[i].now,
                 dir_tbl[i].hand, gap_len());
    end
    cur_now = TIME_MAX;

    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      write_timeout(tmo_plan[ph]);
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        // one phase runs back to back with no idle cycles
        random_item(ph != 3);
      end
    end
    @(negedge clk_i);
    start_i = 1'b0;
    wait_drained();

    if (ack_result_q.size() != 0) begin
      err_cnt++;
    end
    $display("covered %0d beats: %0d records, %0d checks, %0d acks matched, %0d results",
             n_items, n_records, n_checks, n_hits, n_results);
    $display("timeout settings: reset value plus %0d written ones, zero and all-ones included",
             PHASES);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
